### src/lz_token_stream_decoder_core_assert.svh
// Assertion macros shared by the LZ token stream decoder RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef LZ_TOKEN_STREAM_DECODER_CORE_ASSERT_SVH
`define LZ_TOKEN_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LZTSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lztsd check failed");

// Next-cycle implication, disabled during reset.
`define LZTSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lztsd check failed");

`endif

### src/lztsd_pkg.sv
// Shared types and constants for the LZ token stream decoder.
// No dependencies.
package lztsd_pkg;

    localparam int HISTORY_DEPTH_DEF    = 65536;
    localparam int BYTES_PER_RESULT_DEF = 8;

    localparam int          PRODUCED_W   = 17;
    localparam int unsigned PRODUCED_CAP = 65536;
    localparam int          DATA_W       = 64;
    localparam int          COUNT_W      = 4;
    localparam int          LANE_W       = 3;
    localparam int          LEN_W        = 7;

    localparam logic [7:0] MATCH_FLAG = 8'h80;
    localparam logic [7:0] LEN_MASK   = 8'h7F;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_RD     = 4'b0100,
        S_WR     = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        PH_TOKEN = 2'd0,
        PH_DLOW  = 2'd1,
        PH_DHIGH = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIST  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

endpackage

### src/lz_token_stream_decoder_core.sv
// Byte-serial LZ77 token stream decoder with on-chip history RAM.
// Depends on lztsd_pkg and lz_token_stream_decoder_core_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, in_byte, in_last) takes one compressed
//   byte per transfer. Output channel (out_valid/out_ready) returns packed
//   decoded bytes: out_data, out_count, out_last, status. out_last marks the
//   final result caused by one input byte; header bytes give no result
//   unless the buffer ends early or the distance is bad. A literal's byte
//   is registered in DECODE and its result in the output register, and
//   in_ready returns in the same cycle that the result turns valid.
//   A match copies each history byte by a registered RAM read (S_RD), then
//   a write back (S_WR), and starts the next read only after that write.
//   in_ready is high only while the sequencer idles; it does not wait for a
//   pending result to be taken, since the output register holds it.
//   If the receiver stalls, the sequencer stops at the next byte that must
//   produce a result and resumes when the output register frees up.
//   Reset clears parsing, write pointer and produced count; the history RAM
//   is not cleared, distances are checked against the produced count.
//   A byte with in_last ends the buffer and clears the same state.
module lz_token_stream_decoder_core #(
    parameter int HISTORY_DEPTH    = lztsd_pkg::HISTORY_DEPTH_DEF,
    parameter int BYTES_PER_RESULT = lztsd_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lztsd_pkg::DATA_W-1:0]  out_data,
    output logic [lztsd_pkg::COUNT_W-1:0] out_count,
    output logic                          out_last,
    output logic [1:0]                    status
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = lztsd_pkg::PRODUCED_W;

    lztsd_pkg::state_t  state_reg, state_next;
    lztsd_pkg::phase_t  phase_reg, phase_next;
    logic               stopped_reg, stopped_next;
    logic [lztsd_pkg::LEN_W-1:0] len_reg, len_next;
    logic [lztsd_pkg::LEN_W-1:0] remain_reg, remain_next;
    logic [7:0]         dlow_reg, dlow_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]      bp_reg, bp_next;
    logic [lztsd_pkg::LANE_W-1:0] pack_cnt_reg, pack_cnt_next;
    logic [lztsd_pkg::DATA_W-1:0] pack_data_reg, pack_data_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;

    logic                          out_valid_reg, out_valid_next;
    logic [lztsd_pkg::DATA_W-1:0]  out_data_reg, out_data_next;
    logic [lztsd_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                          out_last_reg, out_last_next;
    lztsd_pkg::status_t            out_status_reg, out_status_next;

    logic [7:0] history_mem [HISTORY_DEPTH];
    logic [7:0] rd_data_reg;
    logic       mem_we;
    logic [7:0] mem_wdata;

    logic          out_free;
    logic          finish;
    logic          dec_emit;
    logic [15:0]   match_dist;
    logic          dist_bad;
    logic [PW-1:0] rd_start;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] rd_inc;
    logic [PW-1:0] bp_inc;
    logic          wr_full;
    logic          wr_end;
    logic          wr_emit;
    logic [lztsd_pkg::DATA_W-1:0] merged;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == lztsd_pkg::S_IDLE);

    assign match_dist = {byte_reg, dlow_reg};
    assign dist_bad   = (match_dist == 16'd0) || ({1'b0, match_dist} > bp_reg)
                        || (PW'(match_dist) > PW'(HISTORY_DEPTH));
    assign rd_start   = (PW'(wp_reg) >= PW'(match_dist))
                        ? PW'(wp_reg) - PW'(match_dist)
                        : PW'(wp_reg) + PW'(HISTORY_DEPTH) - PW'(match_dist);

    assign wp_inc = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_inc = (rd_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign bp_inc = (bp_reg == PW'(lztsd_pkg::PRODUCED_CAP)) ? bp_reg : bp_reg + 1'b1;

    assign wr_full = ({1'b0, pack_cnt_reg} == lztsd_pkg::COUNT_W'(BYTES_PER_RESULT - 1));
    assign wr_end  = (remain_reg == lztsd_pkg::LEN_W'(1));
    assign wr_emit = wr_full || wr_end;

    always_comb
    begin
        merged = pack_data_reg;
        merged[pack_cnt_reg * 8 +: 8] = rd_data_reg;
    end

    // Does the byte now in DECODE produce a result?
    always_comb
    begin
        unique case (phase_reg)
            lztsd_pkg::PH_TOKEN: dec_emit = !byte_reg[7] || last_reg;
            lztsd_pkg::PH_DLOW:  dec_emit = last_reg;
            lztsd_pkg::PH_DHIGH: dec_emit = dist_bad;
            default:             dec_emit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        stopped_next    = stopped_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        dlow_next       = dlow_reg;
        wp_next         = wp_reg;
        rd_ptr_next     = rd_ptr_reg;
        bp_next         = bp_reg;
        pack_cnt_next   = pack_cnt_reg;
        pack_data_next  = pack_data_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_wdata       = byte_reg;
        finish          = 1'b0;

        unique case (state_reg)
            lztsd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_byte;
                    last_next  = in_last;
                    state_next = lztsd_pkg::S_DECODE;
                end
            end
            lztsd_pkg::S_DECODE:
            begin
                if (stopped_reg)
                begin
                    finish = 1'b1;
                end
                else if (!dec_emit || out_free)
                begin
                    unique case (phase_reg)
                        lztsd_pkg::PH_TOKEN:
                        begin
                            if ((byte_reg & lztsd_pkg::MATCH_FLAG) != 8'd0)
                            begin
                                len_next   = lztsd_pkg::LEN_W'(byte_reg & lztsd_pkg::LEN_MASK);
                                phase_next = lztsd_pkg::PH_DLOW;
                                if (last_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_data_next   = '0;
                                    out_count_next  = '0;
                                    out_last_next   = 1'b1;
                                    out_status_next = lztsd_pkg::ST_TRUNCATED;
                                end
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                wp_next         = wp_inc;
                                bp_next         = bp_inc;
                                out_valid_next  = 1'b1;
                                out_data_next   = lztsd_pkg::DATA_W'(byte_reg);
                                out_count_next  = lztsd_pkg::COUNT_W'(1);
                                out_last_next   = 1'b1;
                                out_status_next = lztsd_pkg::ST_OK;
                            end
                            finish = 1'b1;
                        end
                        lztsd_pkg::PH_DLOW:
                        begin
                            dlow_next  = byte_reg;
                            phase_next = lztsd_pkg::PH_DHIGH;
                            if (last_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_data_next   = '0;
                                out_count_next  = '0;
                                out_last_next   = 1'b1;
                                out_status_next = lztsd_pkg::ST_TRUNCATED;
                            end
                            finish = 1'b1;
                        end
                        lztsd_pkg::PH_DHIGH:
                        begin
                            phase_next = lztsd_pkg::PH_TOKEN;
                            if (dist_bad)
                            begin
                                stopped_next    = 1'b1;
                                out_valid_next  = 1'b1;
                                out_data_next   = '0;
                                out_count_next  = '0;
                                out_last_next   = 1'b1;
                                out_status_next = lztsd_pkg::ST_BAD_DIST;
                                finish          = 1'b1;
                            end
                            else if (len_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                rd_ptr_next    = rd_start[AW-1:0];
                                remain_next    = len_reg;
                                pack_cnt_next  = '0;
                                pack_data_next = '0;
                                state_next     = lztsd_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                            phase_next = lztsd_pkg::PH_TOKEN;
                            finish     = 1'b1;
                        end
                    endcase
                end
            end
            lztsd_pkg::S_RD:
            begin
                state_next = lztsd_pkg::S_WR;
            end
            lztsd_pkg::S_WR:
            begin
                if (!wr_emit || out_free)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = rd_data_reg;
                    wp_next     = wp_inc;
                    bp_next     = bp_inc;
                    rd_ptr_next = rd_inc;
                    remain_next = remain_reg - 1'b1;
                    if (wr_emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = merged;
                        out_count_next  = lztsd_pkg::COUNT_W'(pack_cnt_reg) + 1'b1;
                        out_last_next   = wr_end;
                        out_status_next = lztsd_pkg::ST_OK;
                        pack_data_next  = '0;
                        pack_cnt_next   = '0;
                    end
                    else
                    begin
                        pack_data_next = merged;
                        pack_cnt_next  = pack_cnt_reg + 1'b1;
                    end
                    if (wr_end)
                        finish = 1'b1;
                    else
                        state_next = lztsd_pkg::S_RD;
                end
            end
            default:
            begin
                state_next = lztsd_pkg::S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = lztsd_pkg::S_IDLE;
            if (last_reg)
            begin
                phase_next   = lztsd_pkg::PH_TOKEN;
                len_next     = '0;
                dlow_next    = '0;
                wp_next      = '0;
                bp_next      = '0;
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lztsd_pkg::S_IDLE;
            phase_reg     <= lztsd_pkg::PH_TOKEN;
            stopped_reg   <= 1'b0;
            len_reg       <= '0;
            remain_reg    <= '0;
            dlow_reg      <= '0;
            wp_reg        <= '0;
            rd_ptr_reg    <= '0;
            bp_reg        <= '0;
            pack_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stopped_reg   <= stopped_next;
            len_reg       <= len_next;
            remain_reg    <= remain_next;
            dlow_reg      <= dlow_next;
            wp_reg        <= wp_next;
            rd_ptr_reg    <= rd_ptr_next;
            bp_reg        <= bp_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        pack_data_reg  <= pack_data_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // History RAM: one write port at the write pointer, registered read at
    // the copy pointer. Reads and writes of a copy fall in different cycles.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            history_mem[wp_reg] <= mem_wdata;
        rd_data_reg <= history_mem[rd_ptr_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;
    assign status    = out_status_reg;

`include "lz_token_stream_decoder_core_assert.svh"

    `LZTSD_ASSERT_IMP(a_count_range, out_valid_reg,
        out_count_reg <= lztsd_pkg::COUNT_W'(BYTES_PER_RESULT))
    `LZTSD_ASSERT_IMP(a_err_empty, out_valid_reg && (out_status_reg != lztsd_pkg::ST_OK),
        (out_count_reg == '0) && (out_data_reg == '0) && out_last_reg)
    `LZTSD_ASSERT_IMP(a_copy_live,
        (state_reg == lztsd_pkg::S_RD) || (state_reg == lztsd_pkg::S_WR),
        !stopped_reg && (remain_reg != '0))
    `LZTSD_ASSERT_NXT(a_accept_decode, in_valid && in_ready,
        state_reg == lztsd_pkg::S_DECODE)

endmodule
